// ===== design/pcm_sample_mixer_unit_defines.svh =====
// Assertion macros for the PCM sample mixer.
// Each macro expects clk and rst_n in scope at the place of use.
`ifndef PCM_SAMPLE_MIXER_UNIT_DEFINES_SVH
`define PCM_SAMPLE_MIXER_UNIT_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, checked out of reset.
`define PSMIX_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PSMIX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PSMIX_ASSERT_NOW(label, ante, cons, msg)
`define PSMIX_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== design/psmix_pkg.sv =====
`default_nettype none

package psmix_pkg;

    // Opcodes
    localparam logic [2:0] OP_WRITE    = 3'd0;
    localparam logic [2:0] OP_START    = 3'd1;
    localparam logic [2:0] OP_GAINS    = 3'd2;
    localparam logic [2:0] OP_STOP     = 3'd3;
    localparam logic [2:0] OP_TICK     = 3'd4;
    localparam logic [2:0] OP_STOP_ALL = 3'd5;

    localparam int          MIX_RATE_HZ = 44100;
    localparam int          VOL_MAX     = 127;
    localparam logic [7:0]  SEP_MAX     = 8'd254;
    localparam logic [8:0]  SILENCE     = 9'd128;
    localparam int          STEP_W      = 17;
    localparam int          GAIN_NUM_W  = 15;
    localparam int          GAIN_W      = 8;
    localparam int          CH_FIELD_W  = 4;

    // step = rate * 65536 / 44100 = rate * 16384 / 11025, taken as
    // (rate * STEP_RECIP) >> STEP_SHIFT; exact for every 16-bit rate.
    localparam int          STEP_RATE_W  = 16;
    localparam int          STEP_RECIP_W = 31;
    localparam int          STEP_RECIP   = 1595663134;
    localparam int          STEP_SHIFT   = 30;

    // gain = num / 127 for any num below 2**15, taken as
    // (num * GAIN_RECIP) >> GAIN_SHIFT.
    localparam int          GAIN_RECIP_W = 16;
    localparam int          GAIN_RECIP   = 33027;
    localparam int          GAIN_SHIFT   = 22;

    typedef struct packed {
        logic [2:0]            opcode;
        logic [CH_FIELD_W-1:0] channel;
        logic [15:0]           address;
        logic [7:0]            sample_byte;
        logic [15:0]           length;
        logic [15:0]           rate;
        logic [6:0]            volume;
        logic [7:0]            separation;
    } item_t;

    typedef struct packed {
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
        logic               any_active;
        logic [15:0]        active_mask;
    } result_t;

    // Controller to datapath
    typedef struct packed {
        logic                  item_load;
        logic                  mem_write;
        logic                  stop;
        logic                  stop_all;
        logic                  div_go;
        logic                  commit;
        logic                  mix_clear;
        logic                  visit;
        logic [CH_FIELD_W-1:0] visit_ch;
        logic                  out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [2:0] opcode;
        logic       div_busy;
    } status_t;

endpackage

`default_nettype wire

// ===== design/psmix_cdiv.sv =====
`default_nettype none

// Division by a constant through a registered reciprocal multiply.
// go captures the numerator into num_reg; quo_reg takes the quotient while busy is high.
module psmix_cdiv #(
    parameter int NUM_W   = 16,
    parameter int QUO_W   = 17,
    parameter int RECIP_W = 31,
    parameter int RECIP   = 1595663134,
    parameter int SHIFT   = 30
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             go,
    input  wire logic [NUM_W-1:0] num,
    output logic                  busy,
    output logic [QUO_W-1:0]      quo
);

    localparam int                 PROD_W  = NUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'(RECIP);

    logic [NUM_W-1:0]  num_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic              busy_reg;
    logic [PROD_W-1:0] prod;

    always_comb
    begin
        prod = PROD_W'(num_reg) * PROD_W'(RECIP_K);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= go;
    end

    always_ff @(posedge clk)
    begin
        if (go)
            num_reg <= num;
        if (busy_reg)
            quo_reg <= prod[SHIFT +: QUO_W];
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

// ===== design/psmix_ctrl.sv =====
`default_nettype none

module psmix_ctrl #(
    parameter int NUM_CHANNELS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    output logic                   result_valid,
    input  wire logic              result_stall,
    input  wire psmix_pkg::status_t status,
    output psmix_pkg::cmd_t        cmd
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [CH_W-1:0] LAST_CH   = CH_W'(NUM_CHANNELS - 1);
    localparam logic [CH_W-1:0] LAST_DRAIN = CH_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIV_WAIT,
        ST_MIX,
        ST_DRAIN,
        ST_OUT
    } state_t;

    state_t          state_reg, state_next;
    logic [CH_W-1:0] cnt_reg, cnt_next;
    logic            result_valid_reg, result_valid_next;

    always_comb
    begin
        cmd               = '0;
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        result_valid_next = result_valid_reg && result_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.item_load = 1'b1;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (status.opcode)
                    psmix_pkg::OP_WRITE:
                    begin
                        cmd.mem_write = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    psmix_pkg::OP_START, psmix_pkg::OP_GAINS:
                    begin
                        cmd.div_go = 1'b1;
                        state_next = ST_DIV_WAIT;
                    end
                    psmix_pkg::OP_STOP:
                    begin
                        cmd.stop   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    psmix_pkg::OP_STOP_ALL:
                    begin
                        cmd.stop_all = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    psmix_pkg::OP_TICK:
                    begin
                        cmd.mix_clear = 1'b1;
                        cnt_next      = '0;
                        state_next    = ST_MIX;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_DIV_WAIT:
            begin
                if (!status.div_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_MIX:
            begin
                // visit one channel per cycle in ascending order
                cmd.visit    = 1'b1;
                cmd.visit_ch = psmix_pkg::CH_FIELD_W'(cnt_reg);
                if (cnt_reg == LAST_CH)
                begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + CH_W'(1);
                end
            end
            ST_DRAIN:
            begin
                // let the product and accumulate stages empty
                if (cnt_reg == LAST_DRAIN)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    cnt_next = cnt_reg + CH_W'(1);
                end
            end
            ST_OUT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    cmd.out_load      = 1'b1;
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign item_stall   = state_reg != ST_IDLE;
    assign result_valid = result_valid_reg;

endmodule

`default_nettype wire

// ===== design/psmix_datapath.sv =====
`default_nettype none

module psmix_datapath #(
    parameter int NUM_CHANNELS     = 16,
    parameter int SAMPLE_ADDR_BITS = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire psmix_pkg::item_t item,
    input  wire psmix_pkg::cmd_t  cmd,
    output psmix_pkg::status_t    status,
    output psmix_pkg::result_t    result
);

    localparam int CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int A_W       = SAMPLE_ADDR_BITS;
    localparam int MEM_DEPTH = 2 ** SAMPLE_ADDR_BITS;
    localparam int STEP_W    = psmix_pkg::STEP_W;
    localparam int GAIN_W    = psmix_pkg::GAIN_W;
    localparam int GNUM_W    = psmix_pkg::GAIN_NUM_W;

    function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
        if (v > 19'sd32767)
            return 16'sh7fff;
        else if (v < -19'sd32768)
            return 16'sh8000;
        else
            return v[15:0];
    endfunction

    psmix_pkg::item_t item_reg;

    // channel state
    logic [A_W-1:0]    base_reg [NUM_CHANNELS];
    logic [15:0]       len_reg  [NUM_CHANNELS];
    logic [31:0]       pos_reg  [NUM_CHANNELS];
    logic [STEP_W-1:0] step_reg [NUM_CHANNELS];
    logic [GAIN_W-1:0] lg_reg   [NUM_CHANNELS];
    logic [GAIN_W-1:0] rg_reg   [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] active_reg;

    logic [7:0] mem [MEM_DEPTH];

    // hold item for the whole operation
    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
            item_reg <= item;
    end

    logic            ch_ok;
    logic [CH_W-1:0] ci;

    assign ch_ok = {1'b0, item_reg.channel} < 5'(NUM_CHANNELS);
    assign ci    = item_reg.channel[CH_W-1:0];

    // gain and step dividers
    logic [7:0]        sep_sat;
    logic [GNUM_W-1:0] lnum, rnum;
    logic [STEP_W-1:0] step_quo;
    logic [GAIN_W-1:0] lquo, rquo;
    logic              step_busy, l_busy, r_busy;

    always_comb
    begin
        sep_sat  = (item_reg.separation > psmix_pkg::SEP_MAX) ? psmix_pkg::SEP_MAX
                                                              : item_reg.separation;
        lnum     = GNUM_W'(psmix_pkg::SEP_MAX - sep_sat) * GNUM_W'(item_reg.volume);
        rnum     = GNUM_W'(sep_sat) * GNUM_W'(item_reg.volume);
    end

    psmix_cdiv #(
        .NUM_W   (psmix_pkg::STEP_RATE_W),
        .QUO_W   (STEP_W),
        .RECIP_W (psmix_pkg::STEP_RECIP_W),
        .RECIP   (psmix_pkg::STEP_RECIP),
        .SHIFT   (psmix_pkg::STEP_SHIFT)
    ) u_step_div (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (cmd.div_go),
        .num   (item_reg.rate),
        .busy  (step_busy),
        .quo   (step_quo)
    );

    psmix_cdiv #(
        .NUM_W   (GNUM_W),
        .QUO_W   (GAIN_W),
        .RECIP_W (psmix_pkg::GAIN_RECIP_W),
        .RECIP   (psmix_pkg::GAIN_RECIP),
        .SHIFT   (psmix_pkg::GAIN_SHIFT)
    ) u_lgain_div (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (cmd.div_go),
        .num   (lnum),
        .busy  (l_busy),
        .quo   (lquo)
    );

    psmix_cdiv #(
        .NUM_W   (GNUM_W),
        .QUO_W   (GAIN_W),
        .RECIP_W (psmix_pkg::GAIN_RECIP_W),
        .RECIP   (psmix_pkg::GAIN_RECIP),
        .SHIFT   (psmix_pkg::GAIN_SHIFT)
    ) u_rgain_div (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (cmd.div_go),
        .num   (rnum),
        .busy  (r_busy),
        .quo   (rquo)
    );

    assign status.opcode   = item_reg.opcode;
    assign status.div_busy = step_busy || l_busy || r_busy;

    // visit stage
    logic [CH_W-1:0] vc;
    logic [15:0]     v_idx;
    logic            v_act, v_end, v_hit;
    logic [A_W-1:0]  rd_addr;
    logic            is_start;

    always_comb
    begin
        vc       = cmd.visit_ch[CH_W-1:0];
        v_act    = active_reg[vc];
        v_idx    = pos_reg[vc][31:16];
        v_end    = v_idx >= len_reg[vc];
        v_hit    = cmd.visit && v_act && !v_end;
        rd_addr  = base_reg[vc] + A_W'(v_idx);
        is_start = item_reg.opcode == psmix_pkg::OP_START;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_reg <= '0;
        else if (cmd.stop_all)
            active_reg <= '0;
        else if (cmd.stop && ch_ok)
            active_reg[ci] <= 1'b0;
        else if (cmd.commit && is_start && ch_ok)
            active_reg[ci] <= 1'b1;
        else if (cmd.visit && v_act && v_end)
            active_reg[vc] <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && ch_ok)
        begin
            lg_reg[ci] <= lquo;
            rg_reg[ci] <= rquo;
            if (is_start)
            begin
                base_reg[ci] <= A_W'(item_reg.address);
                len_reg[ci]  <= item_reg.length;
                pos_reg[ci]  <= '0;
                step_reg[ci] <= step_quo;
            end
        end
        else if (v_hit)
        begin
            pos_reg[vc] <= pos_reg[vc] + 32'(step_reg[vc]);
        end
    end

    // sample memory
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mem_write)
            mem[A_W'(item_reg.address)] <= item_reg.sample_byte;
        if (v_hit)
            rd_data_reg <= mem[rd_addr];
    end

    // product and accumulate stages
    logic              s1_valid_reg, s2_valid_reg;
    logic [GAIN_W-1:0] s1_lg_reg, s1_rg_reg;
    logic signed [8:0]  sample_s, gl_s, gr_s;
    logic signed [17:0] prod_l_next, prod_r_next;
    logic signed [17:0] prod_l_reg, prod_r_reg;
    logic signed [15:0] acc_l_reg, acc_r_reg;
    logic signed [18:0] sum_l, sum_r;
    logic               any_reg;

    always_comb
    begin
        sample_s    = $signed({1'b0, rd_data_reg} - psmix_pkg::SILENCE);
        gl_s        = $signed({1'b0, s1_lg_reg});
        gr_s        = $signed({1'b0, s1_rg_reg});
        prod_l_next = sample_s * gl_s;
        prod_r_next = sample_s * gr_s;
        sum_l       = 19'(acc_l_reg) + 19'(prod_l_reg);
        sum_r       = 19'(acc_r_reg) + 19'(prod_r_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= v_hit;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v_hit)
        begin
            s1_lg_reg <= lg_reg[vc];
            s1_rg_reg <= rg_reg[vc];
        end
        if (s1_valid_reg)
        begin
            prod_l_reg <= prod_l_next;
            prod_r_reg <= prod_r_next;
        end
        if (cmd.mix_clear)
        begin
            acc_l_reg <= '0;
            acc_r_reg <= '0;
        end
        else if (s2_valid_reg)
        begin
            acc_l_reg <= sat16(sum_l);
            acc_r_reg <= sat16(sum_r);
        end
        if (cmd.mix_clear)
            any_reg <= 1'b0;
        else if (cmd.visit && v_act)
            any_reg <= 1'b1;
    end

    // output register
    psmix_pkg::result_t result_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            result_reg.left_sample  <= acc_l_reg;
            result_reg.right_sample <= acc_r_reg;
            result_reg.any_active   <= any_reg;
            result_reg.active_mask  <= 16'(active_reg);
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

// ===== design/pcm_sample_mixer_unit.sv =====
// Mix tick: after accept come decode, one mix state per channel, the drain states and the
//   output state (one channel visit per cycle, at most one memory read each).
// Start and set gains: decode, then wait on the two-stage reciprocal multiply for step and gains.
// Write, stop and stop all: accept, then decode. A finished result waits in the output register.
// Reset (rst_n low, asynchronous): all channels idle, no result pending;
//   sample memory holds whatever it held and is undefined until written.
`default_nettype none

`include "pcm_sample_mixer_unit_defines.svh"

module pcm_sample_mixer_unit #(
    parameter int NUM_CHANNELS     = 16,
    parameter int SAMPLE_ADDR_BITS = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire psmix_pkg::item_t item,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output psmix_pkg::result_t    result
);

    // The controller sequences each operation; the datapath holds channel
    // state, sample memory, the constant dividers and the mix pipeline.
    psmix_pkg::cmd_t    cmd;
    psmix_pkg::status_t status;

    // Control: one item at a time, decode, then divide, visit, write or stop.
    psmix_ctrl #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    // Datapath: visit stage reads channel state and sample memory, then a
    // product stage and a saturating accumulate stage per side.
    psmix_datapath #(
        .NUM_CHANNELS     (NUM_CHANNELS),
        .SAMPLE_ADDR_BITS (SAMPLE_ADDR_BITS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

    // An accepted beat always holds off the next one in the cycle after it.
    `PSMIX_ASSERT_NEXT(a_busy_after_accept, item_valid && !item_stall, item_stall, "accept did not stall")

    // Never overwrite a result beat that is still waiting.
    `PSMIX_ASSERT_NOW(a_no_overwrite, cmd.out_load, !result_valid || !result_stall, "result overwritten")

    // Dividers must be idle while channels are visited.
    `PSMIX_ASSERT_NOW(a_div_idle_in_mix, cmd.visit, !status.div_busy, "divider busy during mix")

    // At most one state-changing command per cycle.
    `PSMIX_ASSERT_NOW(a_one_cmd, 1'b1, $onehot0({cmd.visit, cmd.commit, cmd.mem_write, cmd.stop, cmd.stop_all, cmd.item_load}), "conflicting commands")

endmodule

`default_nettype wire
